### rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    // configuration port geometry
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // register select, taken from paddr[2] (word addresses 0x0 and 0x4)
    localparam logic REG_IDX_MODULUS  = 1'b0;
    localparam logic REG_IDX_EXPONENT = 1'b1;

endpackage

### rtl/mexp_red_cell.sv
`timescale 1ns / 1ps

module mexp_red_cell
    import mexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [VALUE_WIDTH:0]   m,
    input  logic                   in_valid,
    input  logic [VALUE_WIDTH-1:0] in_rem,
    input  logic [VALUE_WIDTH-1:0] in_base,
    output logic                   out_valid,
    output logic [VALUE_WIDTH-1:0] out_rem,
    output logic [VALUE_WIDTH-1:0] out_base
);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] base_reg;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [VALUE_WIDTH-1:0] base_next;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH+1:0] diff;

    // one restoring division step: bring in the next base bit, subtract m if it fits
    always_comb
    begin
        shifted   = {in_rem, in_base[VALUE_WIDTH-1]};
        diff      = {1'b0, shifted} - {1'b0, m};
        rem_next  = diff[VALUE_WIDTH+1] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
        base_next = {in_base[VALUE_WIDTH-2:0], 1'b0};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            base_reg <= base_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_base  = base_reg;

endmodule

### rtl/mexp_mul_cell.sv
`timescale 1ns / 1ps

module mexp_mul_cell
    import mexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int STEP        = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [VALUE_WIDTH:0]   m,
    input  logic                   ebit,
    input  logic                   in_valid,
    input  logic [VALUE_WIDTH-1:0] in_acc,
    input  logic [VALUE_WIDTH-1:0] in_sq,
    input  logic [VALUE_WIDTH-1:0] in_pa,
    input  logic [VALUE_WIDTH-1:0] in_ps,
    output logic                   out_valid,
    output logic [VALUE_WIDTH-1:0] out_acc,
    output logic [VALUE_WIDTH-1:0] out_sq,
    output logic [VALUE_WIDTH-1:0] out_pa,
    output logic [VALUE_WIDTH-1:0] out_ps
);

    localparam int  TW  = VALUE_WIDTH + 3;
    localparam int  BIT = VALUE_WIDTH - 1 - STEP;
    localparam bit  FIN = (STEP == VALUE_WIDTH - 1);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] sq_reg;
    logic [VALUE_WIDTH-1:0] pa_reg;
    logic [VALUE_WIDTH-1:0] ps_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [VALUE_WIDTH-1:0] sq_next;
    logic [VALUE_WIDTH-1:0] pa_next;
    logic [VALUE_WIDTH-1:0] ps_next;

    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [TW-1:0] ta;
    logic [TW-1:0] ts;
    logic [TW-1:0] da1;
    logic [TW-1:0] da2;
    logic [TW-1:0] ds1;
    logic [TW-1:0] ds2;
    logic [VALUE_WIDTH-1:0] ra;
    logic [VALUE_WIDTH-1:0] rs;

    // interleaved modular multiply step, two lanes: acc*sq and sq*sq
    always_comb
    begin
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        ta = {2'b00, in_pa, 1'b0} + (in_acc[BIT] ? {3'b000, in_sq} : '0);
        ts = {2'b00, in_ps, 1'b0} + (in_sq[BIT]  ? {3'b000, in_sq} : '0);
        da1 = ta - m1;
        da2 = ta - m2;
        ds1 = ts - m1;
        ds2 = ts - m2;

        // partial sum is below 3m, so at most two subtractions of m
        if (!da2[TW-1])
            ra = da2[VALUE_WIDTH-1:0];
        else if (!da1[TW-1])
            ra = da1[VALUE_WIDTH-1:0];
        else
            ra = ta[VALUE_WIDTH-1:0];

        if (!ds2[TW-1])
            rs = ds2[VALUE_WIDTH-1:0];
        else if (!ds1[TW-1])
            rs = ds1[VALUE_WIDTH-1:0];
        else
            rs = ts[VALUE_WIDTH-1:0];

        // last step of an exponent bit: commit products, restart partial sums
        if (FIN)
        begin
            acc_next = ebit ? ra : in_acc;
            sq_next  = rs;
            pa_next  = '0;
            ps_next  = '0;
        end
        else
        begin
            acc_next = in_acc;
            sq_next  = in_sq;
            pa_next  = ra;
            ps_next  = rs;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            sq_reg  <= sq_next;
            pa_reg  <= pa_next;
            ps_reg  <= ps_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_sq    = sq_reg;
    assign out_pa    = pa_reg;
    assign out_ps    = ps_reg;

endmodule

### rtl/mexp_skid.sv
`timescale 1ns / 1ps

module mexp_skid
    import mexp_pkg::*;
#(
    parameter int DATA_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;

    assign in_ready = !skid_valid_reg;

    // output register plus one spare entry for a result arriving during a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_data_reg <= in_data;
            end
            else
            begin
                skid_data_reg <= in_data;
            end
        end
        else if (out_valid_reg && out_ready && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps

// Modular exponentiation unit: m_tdata = s_tdata ^ exponent mod modulus.
// Input transfers arrive on the s_ stream, one value per transfer; results leave on
// the m_ stream in the same order, one per input transfer.
// The APB port holds two registers: modulus at 0x0 and exponent at 0x4, both
// VALUE_WIDTH bits, reset to 1. A modulus of 0 means 2^VALUE_WIDTH. Exponent 0
// gives a result of 1. Write registers only when no transfer is in flight.
// Datapath: VALUE_WIDTH division cells reduce the base modulo the modulus, then a
// chain of VALUE_WIDTH*VALUE_WIDTH multiply cells runs right-to-left
// square-and-multiply, one multiplier bit of both products per cell.
// Path: an input transfer passes the division cells, then the multiply cells, then the
// output register before m_tvalid rises.
// Throughput: one transfer per cycle, sustained while no stall freezes the chain.
// Stall: an output register and one spare entry follow the chain; when both are
// full the chain freezes and s_tready drops until m_tready takes a result.
// Reset clears all valid bits and the output stage; registers return to 1.

module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // streaming input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // base_value
    // streaming output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // power_result
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [CFG_ADDR_W-1:0]                 paddr,
    input  logic [CFG_DATA_W-1:0]                 pwdata,
    output logic [CFG_DATA_W-1:0]                 prdata,
    output logic                                  pready
);

    localparam int W   = VALUE_WIDTH;
    localparam int TDW = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int NM  = VALUE_WIDTH * VALUE_WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] exponent_reg;
    logic [W:0]   m_eff;
    logic         adv;
    logic         cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(1);
            exponent_reg <= W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IDX_MODULUS:  modulus_reg  <= pwdata[W-1:0];
                REG_IDX_EXPONENT: exponent_reg <= pwdata[W-1:0];
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_IDX_MODULUS:  prdata[W-1:0] = modulus_reg;
            REG_IDX_EXPONENT: prdata[W-1:0] = exponent_reg;
        endcase
    end

    // zero modulus register stands for 2^W
    assign m_eff = {(modulus_reg == '0), modulus_reg};

    // base reduction chain
    logic         red_v [0:W];
    logic [W-1:0] red_r [0:W];
    logic [W-1:0] red_b [0:W];

    assign red_v[0] = s_tvalid;
    assign red_r[0] = '0;
    assign red_b[0] = s_tdata[W-1:0];

    for (genvar i = 0; i < W; i++)
    begin : g_red
        mexp_red_cell #(
            .VALUE_WIDTH (W)
        ) u_red (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .m         (m_eff),
            .in_valid  (red_v[i]),
            .in_rem    (red_r[i]),
            .in_base   (red_b[i]),
            .out_valid (red_v[i+1]),
            .out_rem   (red_r[i+1]),
            .out_base  (red_b[i+1])
        );
    end

    // square-and-multiply chain, exponent bits from lsb up, W cells per bit
    logic         mul_v   [0:NM];
    logic [W-1:0] mul_acc [0:NM];
    logic [W-1:0] mul_sq  [0:NM];
    logic [W-1:0] mul_pa  [0:NM];
    logic [W-1:0] mul_ps  [0:NM];

    assign mul_v[0]   = red_v[W];
    assign mul_acc[0] = (m_eff == (W+1)'(1)) ? '0 : W'(1);
    assign mul_sq[0]  = red_r[W];
    assign mul_pa[0]  = '0;
    assign mul_ps[0]  = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_ebit
        for (genvar j = 0; j < W; j++)
        begin : g_step
            mexp_mul_cell #(
                .VALUE_WIDTH (W),
                .STEP        (j)
            ) u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .m         (m_eff),
                .ebit      (exponent_reg[k]),
                .in_valid  (mul_v[k*W+j]),
                .in_acc    (mul_acc[k*W+j]),
                .in_sq     (mul_sq[k*W+j]),
                .in_pa     (mul_pa[k*W+j]),
                .in_ps     (mul_ps[k*W+j]),
                .out_valid (mul_v[k*W+j+1]),
                .out_acc   (mul_acc[k*W+j+1]),
                .out_sq    (mul_sq[k*W+j+1]),
                .out_pa    (mul_pa[k*W+j+1]),
                .out_ps    (mul_ps[k*W+j+1])
            );
        end
    end

    // exponent zero yields 1 without reduction
    logic [W-1:0] result;
    assign result = (exponent_reg == '0) ? W'(1) : mul_acc[NM];

    // output stage
    logic [W-1:0] out_data;

    mexp_skid #(
        .DATA_W (W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_v[NM]),
        .in_data   (result),
        .in_ready  (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign s_tready = adv;
    assign m_tdata  = TDW'(out_data);

endmodule

### rtl/mexp_checker.sv
`timescale 1ns / 1ps

module mexp_checker
    import mexp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic                                  pready,
    input logic [CFG_ADDR_W-1:0]                 paddr,
    input logic [CFG_DATA_W-1:0]                 pwdata,
    input logic [CFG_DATA_W-1:0]                 prdata
);

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn during stall");

    // a stalled result keeps its data
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result data changed during stall");

    // input back-pressure only when the output side is full
    a_ready_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output stage empty");

    // a modulus write reads back on the next cycle
    a_modulus_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == REG_IDX_MODULUS)
        |=> (paddr[2] != REG_IDX_MODULUS
             || prdata[VALUE_WIDTH-1:0] == $past(pwdata[VALUE_WIDTH-1:0])))
        else $error("modulus readback mismatch");

endmodule

bind modular_exponentiation_unit mexp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mexp_checker (.*);

### test/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    localparam int VALUE_W     = 16;
    localparam int DATA_W      = ((VALUE_W + 7) / 8) * 8;
    localparam int LATENCY     = VALUE_W * VALUE_W + VALUE_W + 1;
    localparam int STALL_LIMIT = 20 * LATENCY;
    localparam int BLOCK_ITEMS = 100;
    localparam int BLOCKS      = 6;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MODULUS  = {REG_IDX_MODULUS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_EXPONENT = {REG_IDX_EXPONENT, 2'b00};

    // one directed row: setting, value, and the result where it is obvious
    typedef struct packed {
        logic [VALUE_W-1:0] modulus;
        logic [VALUE_W-1:0] exponent;
        logic [VALUE_W-1:0] base;
        logic               known;
        logic [VALUE_W-1:0] result;
    } directed_row_t;

    localparam int DIR_ROWS = 23;
    localparam directed_row_t DIRECTED [DIR_ROWS] = '{
        // reset setting: modulus one, exponent one
        '{16'd1,     16'd1,     16'd0,     1'b1, 16'd0},
        '{16'd1,     16'd1,     16'hFFFF,  1'b1, 16'd0},
        // exponent zero gives one, even for modulus one
        '{16'd1,     16'd0,     16'd5,     1'b1, 16'd1},
        '{16'hFFFF,  16'd0,     16'hFFFF,  1'b1, 16'd1},
        // base equal to or below the modulus
        '{16'hFFFF,  16'd1,     16'hFFFF,  1'b1, 16'd0},
        '{16'hFFFF,  16'd1,     16'hFFFE,  1'b1, 16'hFFFE},
        '{16'hFFFF,  16'd1,     16'd0,     1'b1, 16'd0},
        // modulus zero wraps at 2^16
        '{16'd0,     16'd1,     16'hFFFF,  1'b1, 16'hFFFF},
        '{16'd0,     16'd2,     16'hFFFF,  1'b1, 16'd1},
        '{16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 16'hFFFF},
        '{16'd0,     16'hFFFF,  16'd2,     1'b1, 16'd0},
        '{16'd0,     16'hFFFF,  16'd0,     1'b1, 16'd0},
        // large prime modulus
        '{16'd65521, 16'hFFFF,  16'd12345, 1'b0, 16'd0},
        '{16'd65521, 16'd65520, 16'd12345, 1'b1, 16'd1},
        // small modulus with base far above it
        '{16'd3,     16'd2,     16'hFFFF,  1'b1, 16'd0},
        '{16'd3,     16'd2,     16'hFFFE,  1'b1, 16'd1},
        // textbook key pair, n = 61 * 53
        '{16'd3233,  16'd17,    16'd65,    1'b1, 16'd2790},
        '{16'd3233,  16'd2753,  16'd2790,  1'b1, 16'd65},
        // all exponent bits set: alternating base patterns, then modulus two; last, all zero
        '{16'hFFFF,  16'hFFFF,  16'hAAAA,  1'b0, 16'd0},
        '{16'hFFFF,  16'hFFFF,  16'h5555,  1'b0, 16'd0},
        '{16'd2,     16'hFFFF,  16'hFFFF,  1'b1, 16'd1},
        '{16'd2,     16'hFFFF,  16'hFFFE,  1'b1, 16'd0},
        '{16'd0,     16'd0,     16'd0,     1'b1, 16'd1}
    };

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata  = '0;     // [15:0] base_value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;           // [15:0] power_result
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic               pready;

    // current register values as seen by the predictor
    logic [VALUE_W-1:0] cur_modulus  = 16'd1;
    logic [VALUE_W-1:0] cur_exponent = 16'd1;

    logic [VALUE_W-1:0] expected_powers [$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 error_count    = 0;
    int                 values_sent    = 0;
    int                 results_checked = 0;
    int                 settings_used  = 1;
    int                 quiet_cycles   = 0;

    modular_exponentiation_unit #(.VALUE_WIDTH(VALUE_W)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // base^exponent mod modulus, square-and-multiply from the top bit down
    function automatic logic [VALUE_W-1:0] mod_power(input logic [VALUE_W-1:0] base,
                                                     input logic [VALUE_W-1:0] expo,
                                                     input logic [VALUE_W-1:0] modulus);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        int          i;
        if (expo == '0)
            return VALUE_W'(1);
        m   = (modulus == '0) ? (64'd1 << VALUE_W) : 64'(modulus);
        b   = 64'(base) % m;
        acc = 64'd1 % m;
        for (i = VALUE_W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (expo[i])
                acc = (acc * b) % m;
        end
        return acc[VALUE_W-1:0];
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, m_tdata[VALUE_W-1:0]);
                error_count++;
            end
            else
            begin
                if (m_tdata[VALUE_W-1:0] !== expected_powers[0])
                begin
                    $display("%0t: power_result mismatch, expected %0d, got %0d",
                             $time, expected_powers[0], m_tdata[VALUE_W-1:0]);
                    error_count++;
                end
                void'(expected_powers.pop_front());
                results_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // send one value, then record what it should produce
    task automatic send_value(input logic [VALUE_W-1:0] base, input logic known,
                              input logic [VALUE_W-1:0] result);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(base);
        do
            @(posedge clk);
        while (!s_tready);
        expected_powers.push_back(known ? result : mod_power(base, cur_exponent, cur_modulus));
        values_sent++;
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [VALUE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let the pipeline empty, then load a new key
    task automatic load_key(input logic [VALUE_W-1:0] modulus, input logic [VALUE_W-1:0] expo);
        s_tvalid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write(ADDR_MODULUS, modulus);
        reg_write(ADDR_EXPONENT, expo);
        cur_modulus  = modulus;
        cur_exponent = expo;
        settings_used++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_modulus();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return VALUE_W'($urandom_range(2, 255));
            4:       return 16'd65521;
            default: return VALUE_W'($urandom_range(2, 65535));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_exponent();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return VALUE_W'($urandom_range(2, 20));
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return (cur_modulus == '0) ? VALUE_W'($urandom_range(0, 65535))
                                                : VALUE_W'($urandom_range(0, cur_modulus - 1));
            3:       return cur_modulus;
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int phase;
        int blk;
        int n;

        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        send_idle_pct  = 21;
        recv_stall_pct = 72;
        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (DIRECTED[n].modulus != cur_modulus || DIRECTED[n].exponent != cur_exponent)
                load_key(DIRECTED[n].modulus, DIRECTED[n].exponent);
            send_value(DIRECTED[n].base, DIRECTED[n].known, DIRECTED[n].result);
        end

        // random values under random keys, three idling profiles
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 21; recv_stall_pct = 72; end
                1:       begin send_idle_pct = 72; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (blk = 0; blk < BLOCKS; blk++)
            begin
                load_key(pick_modulus(), pick_exponent());
                for (n = 0; n < BLOCK_ITEMS; n++)
                    send_value(pick_base(), 1'b0, '0);
            end
        end

        // drain and watch for stray results
        s_tvalid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);

        $display("covered %0d values over %0d key settings, %0d results checked",
                 values_sent, settings_used, results_checked);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### modular_exponentiation_unit.f
rtl/mexp_pkg.sv
rtl/mexp_red_cell.sv
rtl/mexp_mul_cell.sv
rtl/mexp_skid.sv
rtl/modular_exponentiation_unit.sv
rtl/mexp_checker.sv
test/modular_exponentiation_unit_tb.sv
